/* hdl/arpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response pattern matcher package
// Codes, register indexes and fixed response texts shared by the matcher, its checker and its testbench.
// ----------------------------------------------------------------------------
package arpm_pkg;

   localparam int DEFAULT_WINDOW_BYTES = 32;
   localparam int PATTERN_MAX          = 32;
   localparam int PATTERN_REGS         = 4;
   localparam int CSR_INDEX_W          = 3;
   localparam int CSR_DATA_W           = 64;
   localparam int LENGTH_W             = 6;
   localparam int TICKS_W              = 16;
   localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd3000;
   localparam logic [TICKS_W-1:0] TICKS_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_WAIT  = 2'd0,
      VERDICT_MATCH = 2'd1,
      VERDICT_FAIL  = 2'd2,
      VERDICT_BUSY  = 2'd3
   } verdict_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_0 = 3'd0,
      CSR_PATTERN_1 = 3'd1,
      CSR_PATTERN_2 = 3'd2,
      CSR_PATTERN_3 = 3'd3,
      CSR_LENGTH    = 3'd4,
      CSR_TIMEOUT   = 3'd5
   } csr_index_type;

   localparam logic [0:4][7:0] ERROR_TEXT = "ERROR";
   localparam logic [0:3][7:0] FAIL_TEXT  = "FAIL";
   localparam logic [0:8][7:0] BUSY_TEXT  = "busy p...";

endpackage

/* hdl/at_response_pattern_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response pattern matcher
// Gives a verdict on the modem response that follows a start transfer.
// ----------------------------------------------------------------------------
// Each request transfer carries a kind (start, received byte, millisecond tick
// or none) and a byte. Every request gives exactly one response transfer with
// the verdict held after it: waiting, expected text found, failure (ERROR,
// FAIL, timeout, empty pattern or zero timeout) or modem busy. The expected
// text, its length and the timeout are set through the write-only CSR port,
// by the user only while the block is idle; the block does not enforce this.
// The window shift, the suffix compares against the window and the tick count
// all settle between the state registers and the verdict register, so the
// response is valid in the cycle after the request transfer. One request is
// taken per cycle while rsp_ready stays high.
// While the response waits, req_ready is low unless rsp_ready is high in the
// same cycle, so a new request is taken as the pending response is taken.
// After reset the block is idle: bytes and ticks leave the verdict at
// waiting until the first start, and no response is pending.
// ----------------------------------------------------------------------------
module at_response_pattern_matcher
   import arpm_pkg::*;
#(
   parameter int WINDOW_BYTES = DEFAULT_WINDOW_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_verdict,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BS_W  = $clog2(WINDOW_BYTES + 1);
   localparam int CMP_W = (BS_W > LENGTH_W) ? BS_W : LENGTH_W;
   localparam int KMAX  = (WINDOW_BYTES < PATTERN_MAX) ? WINDOW_BYTES : PATTERN_MAX;
   localparam logic [BS_W-1:0] BS_FULL = BS_W'(WINDOW_BYTES);

   logic [PATTERN_REGS-1:0][CSR_DATA_W-1:0] pattern_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [TICKS_W-1:0]  timeout_ff;

   logic [7:0]          history_ff [WINDOW_BYTES];
   logic [7:0]          history_in [WINDOW_BYTES];
   logic [BS_W-1:0]     bytes_seen_ff, bytes_seen_in;
   logic [TICKS_W-1:0]  elapsed_ff, elapsed_in;
   logic                finished_ff, finished_in;
   verdict_type         verdict_ff, verdict_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept;
   kind_type            kind;
   logic [PATTERN_MAX-1:0][7:0] pat_bytes;
   logic [7:0]          aligned [PATTERN_MAX];
   logic [LENGTH_W-1:0] len_eff;
   logic [LENGTH_W-1:0] idx;
   logic                pat_hit, error_hit, fail_hit, busy_hit;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign kind        = kind_type'(req_kind);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign pat_bytes   = pattern_ff;
   assign len_eff     = (length_ff > LENGTH_W'(PATTERN_MAX)) ? LENGTH_W'(PATTERN_MAX)
                                                             : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_0: pattern_ff[0] <= csr_wdata;
            CSR_PATTERN_1: pattern_ff[1] <= csr_wdata;
            CSR_PATTERN_2: pattern_ff[2] <= csr_wdata;
            CSR_PATTERN_3: pattern_ff[3] <= csr_wdata;
            CSR_LENGTH:    length_ff     <= csr_wdata[LENGTH_W-1:0];
            CSR_TIMEOUT:   timeout_ff    <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // The expected text is right-aligned so that entry k faces the k-th byte
   // from the newest end of the window.
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         idx        = len_eff - LENGTH_W'(1) - LENGTH_W'(k);
         aligned[k] = pat_bytes[idx[4:0]];
      end
   end

   always_comb begin
      for (int j = 0; j < WINDOW_BYTES - 1; j++) begin
         history_in[j] = history_ff[j + 1];
      end
      history_in[WINDOW_BYTES-1] = req_rx_byte;
   end

   // Window bytes older than those seen since the start are stale; the length
   // checks against the byte count keep them out of every compare.
   always_comb begin
      pat_hit = (CMP_W'(len_eff) <= CMP_W'(bytes_seen_in))
             && (CMP_W'(len_eff) <= CMP_W'(BS_FULL));
      for (int k = 0; k < KMAX; k++) begin
         if ((LENGTH_W'(k) < len_eff) && (history_in[WINDOW_BYTES-1-k] != aligned[k])) begin
            pat_hit = 1'b0;
         end
      end
      error_hit = (bytes_seen_in >= BS_W'(5));
      for (int i = 0; i < 5; i++) begin
         if (history_in[WINDOW_BYTES-5+i] != ERROR_TEXT[i]) begin
            error_hit = 1'b0;
         end
      end
      fail_hit = (bytes_seen_in >= BS_W'(4));
      for (int i = 0; i < 4; i++) begin
         if (history_in[WINDOW_BYTES-4+i] != FAIL_TEXT[i]) begin
            fail_hit = 1'b0;
         end
      end
      busy_hit = (bytes_seen_in >= BS_W'(9));
      for (int i = 0; i < 9; i++) begin
         if (history_in[WINDOW_BYTES-9+i] != BUSY_TEXT[i]) begin
            busy_hit = 1'b0;
         end
      end
   end

   always_comb begin
      bytes_seen_in = (bytes_seen_ff < BS_FULL) ? bytes_seen_ff + BS_W'(1) : bytes_seen_ff;
      elapsed_in    = elapsed_ff;
      finished_in   = finished_ff;
      verdict_in    = verdict_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
      case (kind)
         KIND_START: begin
            elapsed_in  = '0;
            finished_in = (length_ff == '0) || (timeout_ff == '0);
            verdict_in  = finished_in ? VERDICT_FAIL : VERDICT_WAIT;
         end
         KIND_BYTE: begin
            if (!finished_ff) begin
               finished_in = 1'b1;
               if (pat_hit) begin
                  verdict_in = VERDICT_MATCH;
               end else if (error_hit || fail_hit) begin
                  verdict_in = VERDICT_FAIL;
               end else if (busy_hit) begin
                  verdict_in = VERDICT_BUSY;
               end else begin
                  finished_in = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            if (!finished_ff) begin
               elapsed_in = (elapsed_ff < TICKS_MAX) ? elapsed_ff + TICKS_W'(1) : elapsed_ff;
               if (elapsed_in >= timeout_ff) begin
                  finished_in = 1'b1;
                  verdict_in  = VERDICT_FAIL;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && (kind == KIND_BYTE) && !finished_ff) begin
         history_ff <= history_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         elapsed_ff    <= '0;
         finished_ff   <= 1'b1;
         verdict_ff    <= VERDICT_WAIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            elapsed_ff  <= elapsed_in;
            finished_ff <= finished_in;
            verdict_ff  <= verdict_in;
            if (kind == KIND_START) begin
               bytes_seen_ff <= '0;
            end else if ((kind == KIND_BYTE) && !finished_ff) begin
               bytes_seen_ff <= bytes_seen_in;
            end
         end
      end
   end

   a_wait_while_open: assert property (@(posedge clock) disable iff (reset)
      !finished_ff |-> (verdict_ff == VERDICT_WAIT))
      else $error("Open wait shows a verdict other than waiting.");

   a_verdict_held: assert property (@(posedge clock) disable iff (reset)
      (accept && finished_ff && (kind != KIND_START)) |=> $stable(verdict_ff))
      else $error("Finished wait changed its verdict without a start.");

   a_empty_pattern: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == KIND_START) && (length_ff == '0))
      |=> (finished_ff && (verdict_ff == VERDICT_FAIL)))
      else $error("Start with an empty pattern did not fail at once.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= BS_FULL)
      else $error("Byte count exceeds the window depth.");

endmodule

/* tb/sv/arpm_verdict_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response pattern matcher verdict checker
// Watches the request, response and CSR ports of the matcher, works out the
// verdict that each request transfer must give and compares it, in order,
// with every response transfer. Mismatches and unexpected responses are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module arpm_verdict_checker
   import arpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [1:0]             rsp_verdict,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count,
   output int                     match_hits,
   output int                     fail_hits,
   output int                     busy_hits
);

   localparam int WINDOW = 32;
   localparam logic [0:31][7:0] ERROR_TAIL = {"ERROR", {27{8'h00}}};
   localparam logic [0:31][7:0] FAIL_TAIL  = {"FAIL", {28{8'h00}}};
   localparam logic [0:31][7:0] BUSY_TAIL  = {"busy p...", {23{8'h00}}};

   logic [CSR_DATA_W-1:0] pattern_q [PATTERN_REGS];
   logic [LENGTH_W-1:0]   pat_len_q;
   logic [TICKS_W-1:0]    timeout_q;

   logic [7:0]            window_q [WINDOW];
   int unsigned           seen_q;
   logic [TICKS_W-1:0]    ticks_q;
   bit                    done_q;
   verdict_type           verdict_q;

   verdict_type           expected_verdicts [$];
   verdict_type           want;
   int                    faults;
   int                    n_match;
   int                    n_fail;
   int                    n_busy;

   function automatic bit tail_is(logic [0:31][7:0] text, int unsigned len);
      int unsigned i;
      if (len > seen_q || len > WINDOW) return 1'b0;
      for (i = 0; i < len; i++) begin
         if (window_q[WINDOW - len + i] !== text[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void conclude(verdict_type v);
      done_q    = 1'b1;
      verdict_q = v;
      case (v)
         VERDICT_MATCH: n_match++;
         VERDICT_FAIL:  n_fail++;
         VERDICT_BUSY:  n_busy++;
         default: ;
      endcase
   endfunction

   function automatic verdict_type predict_verdict(kind_type kind, logic [7:0] rx);
      logic [0:31][7:0] text;
      int unsigned      len;
      int               i;
      case (kind)
         KIND_START: begin
            for (i = 0; i < WINDOW; i++) window_q[i] = 8'h00;
            seen_q    = 0;
            ticks_q   = '0;
            done_q    = 1'b0;
            verdict_q = VERDICT_WAIT;
            if (pat_len_q == 0 || timeout_q == 0) conclude(VERDICT_FAIL);
         end
         KIND_BYTE: begin
            if (!done_q) begin
               for (i = 0; i < WINDOW - 1; i++) window_q[i] = window_q[i + 1];
               window_q[WINDOW - 1] = rx;
               if (seen_q < WINDOW) seen_q++;
               for (i = 0; i < PATTERN_MAX; i++) text[i] = pattern_q[i / 8][8 * (i % 8) +: 8];
               len = (pat_len_q > PATTERN_MAX) ? PATTERN_MAX : pat_len_q;
               if (tail_is(text, len)) conclude(VERDICT_MATCH);
               else if (tail_is(ERROR_TAIL, 5) || tail_is(FAIL_TAIL, 4))
                  conclude(VERDICT_FAIL);
               else if (tail_is(BUSY_TAIL, 9)) conclude(VERDICT_BUSY);
            end
         end
         KIND_TICK: begin
            if (!done_q) begin
               if (ticks_q < TICKS_MAX) ticks_q++;
               if (ticks_q >= timeout_q) conclude(VERDICT_FAIL);
            end
         end
         default: ;
      endcase
      return verdict_q;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_REGS; i++) pattern_q[i] = '0;
         for (int i = 0; i < WINDOW; i++) window_q[i] = 8'h00;
         pat_len_q = '0;
         timeout_q = TIMEOUT_RESET;
         seen_q    = 0;
         ticks_q   = '0;
         done_q    = 1'b1;
         verdict_q = VERDICT_WAIT;
         expected_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_0, CSR_PATTERN_1, CSR_PATTERN_2, CSR_PATTERN_3:
                  pattern_q[csr_index[1:0]] = csr_wdata;
               CSR_LENGTH:  pat_len_q = csr_wdata[LENGTH_W-1:0];
               CSR_TIMEOUT: timeout_q = csr_wdata[TICKS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(predict_verdict(kind_type'(req_kind), req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("[%0t] response transfer with no request outstanding: verdict %0d",
                           $realtime, rsp_verdict);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_verdict !== want) begin
                  faults++;
                  if (faults <= 10)
                     $display("[%0t] verdict mismatch: expected %0d, got %0d",
                              $realtime, want, rsp_verdict);
               end
            end
         end
      end
      error_count   <= faults;
      pending_count <= expected_verdicts.size();
      match_hits    <= n_match;
      fail_hits     <= n_fail;
      busy_hits     <= n_busy;
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response pattern matcher testbench
// Drives waits made of start, byte, tick and idle transfers into the matcher
// under a series of pattern and timeout settings, with random gaps on the
// request side and random stalls on the response side. The verdict checker
// beside the block predicts and compares every response transfer.
// ----------------------------------------------------------------------------
module testbench;
   import arpm_pkg::*;

   localparam int LIMIT = 1_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_kind = KIND_NONE;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_verdict;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int error_count;
   int pending_count;
   int match_hits;
   int fail_hits;
   int busy_hits;

   int          cycles = 0;
   int          items = 0;
   int          waits = 0;
   int          settings = 0;
   int          rsp_hold = 0;
   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;
   logic [7:0]  pat_bytes [PATTERN_MAX];
   logic [5:0]  pat_len_raw = '0;
   string       alphabet = "OKER\r\n+:0A";

   at_response_pattern_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   arpm_verdict_checker verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_verdict   (rsp_verdict),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .match_hits    (match_hits),
      .fail_hits     (fail_hits),
      .busy_hits     (busy_hits)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycles, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The response side stalls at random, or for a counted hold-off when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= !(rsp_idling && $urandom_range(0, 99) < 12);
         end
      end
   end

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   function automatic void make_pattern(bit wide);
      int i;
      for (i = 0; i < PATTERN_MAX; i++)
         pat_bytes[i] = wide ? 8'($urandom_range(0, 255)) : noise_byte();
   endfunction

   function automatic logic [63:0] pattern_word(int r);
      logic [63:0] w;
      int          i;
      w = '0;
      for (i = 0; i < 8; i++) w[8 * i +: 8] = pat_bytes[8 * r + i];
      return w;
   endfunction

   task automatic offer(kind_type kind, logic [7:0] rx);
      while (req_idling && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      items++;
   endtask

   task automatic offer_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) offer(KIND_BYTE, s[i]);
   endtask

   // A corrupted copy has one byte flipped, so the wait usually goes on.
   task automatic offer_pattern(bit corrupt);
      int         len;
      int         spoil;
      int         i;
      logic [7:0] b;
      len   = (pat_len_raw > PATTERN_MAX) ? PATTERN_MAX : pat_len_raw;
      spoil = (len > 0) ? $urandom_range(0, len - 1) : 0;
      for (i = 0; i < len; i++) begin
         b = pat_bytes[i];
         if (corrupt && i == spoil) b = b ^ 8'($urandom_range(1, 255));
         offer(KIND_BYTE, b);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [5:0] len, logic [15:0] tmo);
      csr_put(CSR_PATTERN_0, pattern_word(0));
      csr_put(CSR_PATTERN_1, pattern_word(1));
      csr_put(CSR_PATTERN_2, pattern_word(2));
      csr_put(CSR_PATTERN_3, pattern_word(3));
      csr_put(CSR_LENGTH, {58'd0, len});
      csr_put(CSR_TIMEOUT, {48'd0, tmo});
      csr_we      <= 1'b0;
      pat_len_raw = len;
      settings++;
   endtask

   task automatic run_waits(int target);
      int goal;
      int steps;
      int pick;
      goal = items + target;
      while (items < goal) begin
         offer(KIND_START, noise_byte());
         waits++;
         steps = $urandom_range(1, 10);
         repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) offer(KIND_BYTE, noise_byte());
            else if (pick < 55) offer_pattern($urandom_range(0, 3) == 0);
            else if (pick < 62) begin
               if ($urandom_range(0, 1) != 0) offer_text("ERROR");
               else offer_text("FAIL");
            end
            else if (pick < 68) begin
               if ($urandom_range(0, 2) == 0) offer_text("busy p..");
               else offer_text("busy p...");
            end
            else if (pick < 88) offer(KIND_TICK, noise_byte());
            else if (pick < 95) offer(KIND_NONE, noise_byte());
            else offer(KIND_START, noise_byte());
         end
      end
   endtask

   task automatic run_phase(logic [5:0] len, logic [15:0] tmo, bit wide, int hold,
                            int target);
      settle();
      make_pattern(wide);
      configure(len, tmo);
      if (hold > 0) rsp_hold = hold;
      run_waits(target);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Idle after reset, then a start with an empty pattern.
      offer(KIND_BYTE, 8'hFF);
      offer(KIND_TICK, 8'h00);
      offer(KIND_NONE, 8'h00);
      offer(KIND_START, 8'hFF);
      offer(KIND_BYTE, 8'h00);

      // Zero timeout fails at once.
      settle();
      make_pattern(1'b0);
      pat_bytes[0] = "F";
      pat_bytes[1] = "A";
      pat_bytes[2] = "I";
      pat_bytes[3] = "L";
      configure(6'd4, 16'd0);
      offer(KIND_START, 8'h00);

      // The expected text outranks the failure text; then a two tick timeout.
      settle();
      configure(6'd4, 16'd2);
      offer(KIND_START, 8'h00);
      offer_text("FAIL");
      offer(KIND_TICK, 8'h00);
      offer(KIND_START, 8'h00);
      offer(KIND_TICK, 8'h00);
      offer(KIND_TICK, 8'h00);

      // An over-long pattern cannot match in a short window; busy is reported.
      settle();
      make_pattern(1'b1);
      configure(6'd63, 16'hFFFF);
      offer(KIND_START, 8'h00);
      offer_text("busy p...");

      run_phase(6'($urandom_range(1, 4)), 16'($urandom_range(3, 15)), 1'b0, 0, 350);
      run_phase(6'd32, 16'hFFFF, 1'b0, 0, 350);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      run_phase(6'd1, 16'd1, 1'b0, 0, 350);
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      run_phase(6'($urandom_range(5, 12)), 16'($urandom_range(20, 200)), 1'b1, 400, 350);
      run_phase(6'($urandom_range(33, 63)), 16'($urandom_range(2, 40)), 1'b0, 0, 350);
      run_phase(6'($urandom_range(1, 31)), 16'd0, 1'b1, 0, 150);

      // One long wait runs the tick counter up to a timeout of a hundred ticks.
      settle();
      make_pattern(1'b0);
      configure(6'd3, 16'd100);
      offer(KIND_START, 8'h00);
      waits++;
      repeat (100) offer(KIND_TICK, noise_byte());
      offer(KIND_BYTE, pat_bytes[0]);

      settle();
      $display("Covered %0d request transfers in %0d waits under %0d settings.",
               items, waits, settings);
      $display("Verdicts reached: %0d expected text, %0d failure, %0d busy; %0d errors.",
               match_hits, fail_hits, busy_hits, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/arpm_pkg.sv
hdl/at_response_pattern_matcher.sv
tb/sv/arpm_verdict_checker.sv
tb/sv/testbench.sv
